>>> design/spdc_pkg.sv
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared types and constants for the sync packet deframer with checksum.
// ----------------------------------------------------------------------------
package spdc_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SYNC_FIRST   = 3'd0;
    localparam logic [2:0] REG_SYNC_SECOND  = 3'd1;
    localparam logic [2:0] REG_END_MARKER   = 3'd2;
    localparam logic [2:0] REG_OWN_ADDRESS  = 3'd3;
    localparam logic [2:0] REG_SPEAK_CODE   = 3'd4;
    localparam logic [2:0] REG_NORMAL_CODE  = 3'd5;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_SYNC1 = 4'd0;
    localparam logic [POS_W-1:0] POS_SYNC2 = 4'd1;
    localparam logic [POS_W-1:0] POS_ADDR  = 4'd2;
    localparam logic [POS_W-1:0] POS_FUNC  = 4'd3;
    localparam logic [POS_W-1:0] POS_DATA0 = 4'd4;
    localparam logic [POS_W-1:0] POS_DATA1 = 4'd5;
    localparam logic [POS_W-1:0] POS_DATA2 = 4'd6;
    localparam logic [POS_W-1:0] POS_DATA3 = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK = 4'd8;
    localparam logic [POS_W-1:0] POS_STOP  = 4'd9;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_REJECT   = 3'd1,
        ST_REQUEST  = 3'd2,
        ST_MESSAGE  = 3'd3,
        ST_NOT_OURS = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] own_address;
        logic [BYTE_W-1:0] speak_request_code;
        logic [BYTE_W-1:0] normal_message_code;
    } cfg_t;

endpackage

>>> design/spdc_rx_if.sv
// ----------------------------------------------------------------------------
// spdc_rx_if
// Received byte channel: valid/ready handshake carrying one byte.
// ----------------------------------------------------------------------------
interface spdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/spdc_res_if.sv
// ----------------------------------------------------------------------------
// spdc_res_if
// Result channel: frame status, function byte and four data bytes.
// ----------------------------------------------------------------------------
interface spdc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_status;
    logic [7:0] frame_function;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
    logic [7:0] payload_third;
    logic [7:0] payload_fourth;

    modport source (
        output valid, output frame_status, output frame_function,
        output payload_first, output payload_second,
        output payload_third, output payload_fourth,
        input ready
    );
    modport sink (
        input valid, input frame_status, input frame_function,
        input payload_first, input payload_second,
        input payload_third, input payload_fourth,
        output ready
    );
endinterface

>>> design/spdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// spdc_cfg_regs
// APB-style register file holding sync, stop, address and function codes.
// ----------------------------------------------------------------------------
module spdc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spdc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spdc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output spdc_pkg::cfg_t                 cfg
);
    import spdc_pkg::*;

    cfg_t             cfg_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] rd_byte;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_byte = pwdata[BYTE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SYNC_FIRST:  cfg_reg.sync_first          <= wr_byte;
                REG_SYNC_SECOND: cfg_reg.sync_second         <= wr_byte;
                REG_END_MARKER:  cfg_reg.end_marker          <= wr_byte;
                REG_OWN_ADDRESS: cfg_reg.own_address         <= wr_byte;
                REG_SPEAK_CODE:  cfg_reg.speak_request_code  <= wr_byte;
                REG_NORMAL_CODE: cfg_reg.normal_message_code <= wr_byte;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SYNC_FIRST:  rd_byte = cfg_reg.sync_first;
            REG_SYNC_SECOND: rd_byte = cfg_reg.sync_second;
            REG_END_MARKER:  rd_byte = cfg_reg.end_marker;
            REG_OWN_ADDRESS: rd_byte = cfg_reg.own_address;
            REG_SPEAK_CODE:  rd_byte = cfg_reg.speak_request_code;
            REG_NORMAL_CODE: rd_byte = cfg_reg.normal_message_code;
            default:         rd_byte = '0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

endmodule

>>> design/spdc_deframer.sv
// ----------------------------------------------------------------------------
// spdc_deframer
// Frame position tracking, checksum and classification, with result register.
// ----------------------------------------------------------------------------
module spdc_deframer (
    input  logic           clk,
    input  logic           rst_n,
    input  spdc_pkg::cfg_t cfg,
    spdc_rx_if.sink        rx,
    spdc_res_if.source     res
);
    import spdc_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] addr_reg;
    logic [BYTE_W-1:0] func_reg;
    logic [BYTE_W-1:0] data_reg [4];

    logic              res_valid_reg;
    status_t           status_reg;
    logic [BYTE_W-1:0] res_func_reg;
    logic [BYTE_W-1:0] res_data_reg [4];

    logic              accept;
    logic [BYTE_W-1:0] b;
    status_t           status;
    logic              complete;

    // Output register may be refilled in the same cycle it is drained
    assign rx.ready = !res_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        status   = ST_WAIT;
        complete = 1'b0;
        case (pos_reg)
            POS_SYNC1:
            begin
                if (b == cfg.sync_first)
                begin
                    pos_next = POS_SYNC2;
                end
                else
                begin
                    pos_next = POS_SYNC1;
                    status   = ST_REJECT;
                end
            end
            POS_SYNC2:
            begin
                if (b == cfg.sync_second)
                begin
                    pos_next = POS_ADDR;
                end
                else
                begin
                    pos_next = POS_SYNC1;
                    status   = ST_REJECT;
                end
            end
            POS_ADDR:
            begin
                sum_next = b;
                pos_next = POS_FUNC;
            end
            POS_FUNC, POS_DATA0, POS_DATA1, POS_DATA2, POS_DATA3:
            begin
                sum_next = sum_reg + b;
                pos_next = pos_reg + 4'd1;
            end
            POS_CHECK:
            begin
                if (b == sum_reg)
                begin
                    pos_next = POS_STOP;
                end
                else
                begin
                    pos_next = POS_SYNC1;
                    status   = ST_REJECT;
                end
            end
            POS_STOP:
            begin
                pos_next = POS_SYNC1;
                if (b != cfg.end_marker)
                    status = ST_REJECT;
                else if (addr_reg != cfg.own_address)
                    status = ST_NOT_OURS;
                else if (func_reg == cfg.speak_request_code)
                    status = ST_REQUEST;
                else if (func_reg == cfg.normal_message_code)
                    status = ST_MESSAGE;
                else
                    status = ST_REJECT;
                complete = (status != ST_REJECT);
            end
            default:
            begin
                // unreachable positions behave as hunting
                if (b == cfg.sync_first)
                begin
                    pos_next = POS_SYNC2;
                end
                else
                begin
                    pos_next = POS_SYNC1;
                    status   = ST_REJECT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_SYNC1;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
            status_reg    <= ST_WAIT;
        end
        else
        begin
            if (accept)
            begin
                pos_reg    <= pos_next;
                sum_reg    <= sum_next;
                status_reg <= status;
            end
            if (rx.ready)
                res_valid_reg <= rx.valid;
        end
    end

    // Frame stores and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (pos_reg == POS_ADDR)
                addr_reg <= b;
            if (pos_reg == POS_FUNC)
                func_reg <= b;
            if (pos_reg == POS_DATA0 || pos_reg == POS_DATA1 ||
                pos_reg == POS_DATA2 || pos_reg == POS_DATA3)
                data_reg[pos_reg[1:0]] <= b;

            res_func_reg <= complete ? func_reg : '0;
            for (int k = 0; k < 4; k++)
                res_data_reg[k] <= complete ? data_reg[k] : '0;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.frame_status   = status_reg;
    assign res.frame_function = res_func_reg;
    assign res.payload_first  = res_data_reg[0];
    assign res.payload_second = res_data_reg[1];
    assign res.payload_third  = res_data_reg[2];
    assign res.payload_fourth = res_data_reg[3];

endmodule

>>> design/sync_packet_deframer_checksum_unit.sv
// ----------------------------------------------------------------------------
// sync_packet_deframer_checksum_unit
// Byte-serial frame recogniser with 8-bit additive checksum and APB config.
// ----------------------------------------------------------------------------
// Each accepted byte's status is registered and appears on the result channel in the next cycle.
// Throughput: 1 byte per cycle; the result register is refilled in the cycle
// it is drained, so the only stall is a held result request.
// Reset: rst_n clears position, running sum, result valid and all config
// registers; frame byte stores are not cleared.
module sync_packet_deframer_checksum_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spdc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spdc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    spdc_rx_if.sink                        rx,
    spdc_res_if.source                     res
);
    import spdc_pkg::*;

    cfg_t cfg;

    spdc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spdc_deframer u_deframer (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .res   (res)
    );

    // every accepted byte produces a result in the following cycle
    a_byte_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready) |=> res.valid
    ) else $error("accepted byte produced no result");

    // waiting and rejected results carry no frame contents
    a_no_contents_unless_complete: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res.valid && (res.frame_status == ST_WAIT || res.frame_status == ST_REJECT))
        |-> (res.frame_function == '0 && res.payload_first == '0 &&
             res.payload_second == '0 && res.payload_third == '0 &&
             res.payload_fourth == '0)
    ) else $error("frame contents on incomplete result");

    // the input side is never refused while the result register is free
    a_ready_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!res.valid || res.ready) |-> rx.ready
    ) else $error("input stalled with free result register");

endmodule
